FILE: sv/sipu_pkg.sv
package sipu_pkg;

    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

endpackage

FILE: sv/sipu_front.sv
module sipu_front #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [COORD_BITS-1:0]     i_coord [8],
    output logic                             o_valid,
    output logic                             o_par,
    output logic signed [3*COORD_BITS+3+FRAC_BITS:0] o_num,
    output logic signed [2*COORD_BITS+2:0]   o_den,
    output logic signed [COORD_BITS:0]       o_ps,
    output logic signed [COORD_BITS:0]       o_qs,
    output logic signed [2*COORD_BITS+1:0]   o_rs,
    output logic [8*COORD_BITS-1:0]          o_bnd
);
    localparam int C  = COORD_BITS;
    localparam int NY = 3*C+4+FRAC_BITS;

    // Stage 1: deltas, general-form coefficients and the two products of R.
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic signed [C:0]     r_p1 [2];
    logic signed [C:0]     r_q1 [2];
    logic signed [2*C:0]   r_ma [2];
    logic signed [2*C:0]   r_mb [2];
    logic                  r_vert [2];
    logic                  r_hor [2];
    logic signed [C-1:0]   r_x1 [2];
    logic signed [C-1:0]   r_y1 [2];
    logic [8*C-1:0]        r_bnd1, r_bnd2, r_bnd3, r_bnd4;

    logic signed [C:0]     r_p2 [2];
    logic signed [C:0]     r_q2 [2];
    logic signed [2*C+1:0] r_r2 [2];

    logic signed [2*C+1:0] r_da, r_db;
    logic signed [3*C+2:0] r_na, r_nb;
    logic signed [C:0]     r_ps3, r_qs3;
    logic signed [2*C+1:0] r_rs3;

    logic                  r_par4;
    logic signed [NY-1:0]  r_num4;
    logic signed [2*C+2:0] r_den4;
    logic signed [C:0]     r_ps4, r_qs4;
    logic signed [2*C+1:0] r_rs4;

    logic [8*C-1:0]        n_bnd;

    for (genvar s = 0; s < 2; s++) begin : g_seg
        logic signed [C-1:0] x1, y1, x2, y2;
        logic signed [C:0]   dx, dy;
        logic                vert, hor;
        assign x1   = i_coord[4*s];
        assign y1   = i_coord[4*s+1];
        assign x2   = i_coord[4*s+2];
        assign y2   = i_coord[4*s+3];
        assign dx   = (C+1)'(x2) - (C+1)'(x1);
        assign dy   = (C+1)'(y1) - (C+1)'(y2);
        assign vert = (dx == '0);
        assign hor  = (dy == '0);

        // Bounds per segment: x low, x high, y low, y high.
        assign n_bnd[(4*s+0)*C +: C] = (x1 < x2) ? x1 : x2;
        assign n_bnd[(4*s+1)*C +: C] = (x1 < x2) ? x2 : x1;
        assign n_bnd[(4*s+2)*C +: C] = (y1 < y2) ? y1 : y2;
        assign n_bnd[(4*s+3)*C +: C] = (y1 < y2) ? y2 : y1;

        always_ff @(posedge i_clk) begin
            r_p1[s]   <= vert ? (C+1)'(1) : (hor ? '0 : dy);
            r_q1[s]   <= vert ? '0 : (hor ? (C+1)'(1) : dx);
            r_ma[s]   <= (2*C+1)'(y2) * (2*C+1)'(dx);
            r_mb[s]   <= (2*C+1)'(x2) * (2*C+1)'(dy);
            r_vert[s] <= vert;
            r_hor[s]  <= hor;
            r_x1[s]   <= x1;
            r_y1[s]   <= y1;
        end

        always_ff @(posedge i_clk) begin
            r_p2[s] <= r_p1[s];
            r_q2[s] <= r_q1[s];
            if (r_vert[s]) begin
                r_r2[s] <= (2*C+2)'(r_x1[s]);
            end else if (r_hor[s]) begin
                r_r2[s] <= (2*C+2)'(r_y1[s]);
            end else begin
                r_r2[s] <= (2*C+2)'(r_ma[s]) + (2*C+2)'(r_mb[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bnd1 <= n_bnd;
        r_bnd2 <= r_bnd1;
        r_bnd3 <= r_bnd2;
        r_bnd4 <= r_bnd3;

        r_da  <= (2*C+2)'(r_p2[0]) * (2*C+2)'(r_q2[1]);
        r_db  <= (2*C+2)'(r_q2[0]) * (2*C+2)'(r_p2[1]);
        r_na  <= (3*C+3)'(r_p2[1]) * (3*C+3)'(r_r2[0]);
        r_nb  <= (3*C+3)'(r_r2[1]) * (3*C+3)'(r_p2[0]);
        // The x equation comes from the first line unless its x coefficient is zero.
        r_ps3 <= (r_p2[0] != '0) ? r_p2[0] : r_p2[1];
        r_qs3 <= (r_p2[0] != '0) ? r_q2[0] : r_q2[1];
        r_rs3 <= (r_p2[0] != '0) ? r_r2[0] : r_r2[1];

        r_par4 <= ((2*C+3)'(r_da) - (2*C+3)'(r_db)) == '0;
        r_den4 <= (2*C+3)'(r_db) - (2*C+3)'(r_da);
        r_num4 <= (NY'((3*C+4)'(r_na) - (3*C+4)'(r_nb))) <<< FRAC_BITS;
        r_ps4  <= r_ps3;
        r_qs4  <= r_qs3;
        r_rs4  <= r_rs3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
    assign o_par   = r_par4;
    assign o_num   = r_num4;
    assign o_den   = r_den4;
    assign o_ps    = r_ps4;
    assign o_qs    = r_qs4;
    assign o_rs    = r_rs4;
    assign o_bnd   = r_bnd4;

endmodule

FILE: sv/sipu_div.sv
module sipu_div #(
    parameter int NW = 68,
    parameter int DW = 35,
    parameter int SW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [NW:0]   o_quot,
    output logic [SW-1:0]        o_side
);
    // One quotient bit per stage, restoring, on magnitudes; floor fix-up at the end.
    logic          r_v    [NW+1];
    logic [NW-1:0] r_nq   [NW+1];
    logic [DW-1:0] r_rem  [NW+1];
    logic [DW-1:0] r_d    [NW+1];
    logic          r_neg  [NW+1];
    logic [SW-1:0] r_side [NW+1];
    logic          r_vo;
    logic [NW:0]   r_quot;
    logic [SW-1:0] r_sideo;

    always_ff @(posedge i_clk) begin
        r_nq[0]   <= i_num[NW-1] ? NW'(-i_num) : i_num;
        r_d[0]    <= i_den[DW-1] ? DW'(-i_den) : i_den;
        r_neg[0]  <= i_num[NW-1] ^ i_den[DW-1];
        r_rem[0]  <= '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   n_rem;
        assign trial = {r_rem[k], r_nq[k][NW-1]};
        assign ge    = trial >= {1'b0, r_d[k]};
        assign n_rem = ge ? trial - {1'b0, r_d[k]} : trial;

        always_ff @(posedge i_clk) begin
            r_nq[k+1]   <= {r_nq[k][NW-2:0], ge};
            r_rem[k+1]  <= n_rem[DW-1:0];
            r_d[k+1]    <= r_d[k];
            r_neg[k+1]  <= r_neg[k];
            r_side[k+1] <= r_side[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_neg[NW]) begin
            r_quot <= (r_rem[NW] != '0) ? ~{1'b0, r_nq[NW]} : -{1'b0, r_nq[NW]};
        end else begin
            r_quot <= {1'b0, r_nq[NW]};
        end
        r_sideo <= r_side[NW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NW; k++) begin
                r_v[k] <= 1'b0;
            end
            r_vo <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < NW; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_vo <= r_v[NW];
        end
    end

    assign o_valid = r_vo;
    assign o_quot  = $signed(r_quot);
    assign o_side  = r_sideo;

endmodule

FILE: sv/sipu_xcalc.sv
module sipu_xcalc #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic                                    i_par,
    input  logic signed [3*COORD_BITS+4+FRAC_BITS:0] i_y,
    input  logic signed [COORD_BITS:0]              i_ps,
    input  logic signed [COORD_BITS:0]              i_qs,
    input  logic signed [2*COORD_BITS+1:0]          i_rs,
    input  logic [8*COORD_BITS-1:0]                 i_bnd,
    output logic                                    o_valid,
    output logic                                    o_par,
    output logic                                    o_oky,
    output logic signed [COORD_BITS+FRAC_BITS:0]    o_yt,
    output logic signed [2*COORD_BITS+FRAC_BITS+2:0] o_xnum,
    output logic signed [COORD_BITS:0]              o_pden,
    output logic [4*COORD_BITS-1:0]                 o_xbnd
);
    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int YW = 3*C+5+F;
    localparam int YT = C+F+1;
    localparam int LW = YT/2;
    localparam int HW = YT-LW;
    localparam int NX = 2*C+F+3;

    logic                  r_v1, r_v2, r_v3;
    logic                  r_par1, r_par2, r_par3;
    logic                  r_oky1, r_oky2, r_oky3;
    logic signed [YT-1:0]  r_yt1, r_yt2, r_yt3;
    logic signed [C:0]     r_p1, r_p2, r_p3;
    logic signed [C:0]     r_q1;
    logic signed [2*C+1:0] r_r1, r_r2;
    logic [4*C-1:0]        r_xb1, r_xb2, r_xb3;
    logic signed [C+LW+1:0] r_plo;
    logic signed [C+HW:0]  r_phi;
    logic signed [NX-1:0]  r_xnum;

    logic [1:0]            n_oky;

    // y has to lie inside both segments' y ranges; only then is its narrow form used.
    for (genvar s = 0; s < 2; s++) begin : g_ychk
        logic signed [C-1:0]  lo, hi;
        logic signed [YW-1:0] lo_s, hi_s;
        assign lo    = i_bnd[(4*s+2)*C +: C];
        assign hi    = i_bnd[(4*s+3)*C +: C];
        assign lo_s  = YW'(lo) <<< F;
        assign hi_s  = YW'(hi) <<< F;
        assign n_oky[s] = (i_y >= lo_s) && (i_y <= hi_s);
    end

    always_ff @(posedge i_clk) begin
        r_par1 <= i_par;
        r_oky1 <= &n_oky;
        r_yt1  <= i_y[YT-1:0];
        r_p1   <= i_ps;
        r_q1   <= i_qs;
        r_r1   <= i_rs;
        r_xb1  <= {i_bnd[4*C +: 2*C], i_bnd[0 +: 2*C]};

        r_plo  <= (C+LW+2)'(r_q1) * (C+LW+2)'($signed({1'b0, r_yt1[LW-1:0]}));
        r_phi  <= (C+HW+1)'(r_q1) * (C+HW+1)'($signed(r_yt1[YT-1:LW]));
        r_par2 <= r_par1;
        r_oky2 <= r_oky1;
        r_yt2  <= r_yt1;
        r_p2   <= r_p1;
        r_r2   <= r_r1;
        r_xb2  <= r_xb1;

        r_xnum <= (NX'(r_r2) <<< F) - ((NX'(r_phi) <<< LW) + NX'(r_plo));
        r_par3 <= r_par2;
        r_oky3 <= r_oky2;
        r_yt3  <= r_yt2;
        r_p3   <= r_p2;
        r_xb3  <= r_xb2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_par   = r_par3;
    assign o_oky   = r_oky3;
    assign o_yt    = r_yt3;
    assign o_xnum  = r_xnum;
    assign o_pden  = r_p3;
    assign o_xbnd  = r_xb3;

endmodule

FILE: sv/segment_intersection_point_unit.sv
// Segment intersection point unit.
// An item is two line segments, eight signed coordinates on i_seg_*. It is
// accepted at a rising edge where i_start is high and o_busy is low. Each item
// yields one result: o_hit_status (hit, parallel, or crossing outside the
// segments) and the crossing point o_isect_x / o_isect_y in signed Q16.16,
// zero unless the status is a hit. The result is shown with o_valid high for
// exactly one cycle; there is no back-pressure on the result side.
// The block is fully pipelined and takes one item every cycle; o_busy is high
// only during reset. Latency is set mostly by the two bit-per-stage dividers:
// one of 3*COORD_BITS+FRAC_BITS+4 stages for y, one of 2*COORD_BITS+FRAC_BITS+3
// stages for x.
// Synchronous reset clears every valid bit, so items in flight are dropped
// and no result appears until new items arrive.
module segment_intersection_point_unit #(
    parameter int COORD_BITS = sipu_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = sipu_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [COORD_BITS-1:0] i_seg_a_x1,
    input  logic signed [COORD_BITS-1:0] i_seg_a_y1,
    input  logic signed [COORD_BITS-1:0] i_seg_a_x2,
    input  logic signed [COORD_BITS-1:0] i_seg_a_y2,
    input  logic signed [COORD_BITS-1:0] i_seg_b_x1,
    input  logic signed [COORD_BITS-1:0] i_seg_b_y1,
    input  logic signed [COORD_BITS-1:0] i_seg_b_x2,
    input  logic signed [COORD_BITS-1:0] i_seg_b_y2,
    output logic                         o_valid,
    output logic [1:0]                   o_hit_status,
    output logic signed [31:0]           o_isect_x,
    output logic signed [31:0]           o_isect_y
);
    import sipu_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int NY  = 3*C+4+F;
    localparam int DY  = 2*C+3;
    localparam int YT  = C+F+1;
    localparam int NX  = 2*C+F+3;
    localparam int SYW = 1 + 2*(C+1) + (2*C+2) + 8*C;
    localparam int SXW = 2 + YT + 4*C;
    localparam int SWD = (YT > 33) ? YT : 33;

    localparam logic signed [SWD-1:0] SAT_MAX = SWD'(33'sh0_7FFF_FFFF);
    localparam logic signed [SWD-1:0] SAT_MIN = SWD'(33'sh1_8000_0000);

    logic                  r_busy;
    logic signed [C-1:0]   coord [8];

    logic                  f_valid, f_par;
    logic signed [NY-1:0]  f_num;
    logic signed [DY-1:0]  f_den;
    logic signed [C:0]     f_ps, f_qs;
    logic signed [2*C+1:0] f_rs;
    logic [8*C-1:0]        f_bnd;

    logic                  y_valid;
    logic signed [NY:0]    y_quot;
    logic [SYW-1:0]        y_side;

    logic                  c_valid, c_par, c_oky;
    logic signed [YT-1:0]  c_yt;
    logic signed [NX-1:0]  c_xnum;
    logic signed [C:0]     c_pden;
    logic [4*C-1:0]        c_xbnd;

    logic                  x_valid;
    logic signed [NX:0]    x_quot;
    logic [SXW-1:0]        x_side;

    logic                  x_par, x_oky;
    logic signed [YT-1:0]  x_yt;
    logic [4*C-1:0]        x_xbnd;
    logic [1:0]            n_okx;
    logic signed [SWD-1:0] x_ext, y_ext;
    t_status               n_status;

    logic                  r_valid;
    t_status               r_status;
    logic signed [31:0]    r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign o_busy = r_busy;

    assign coord[0] = i_seg_a_x1;
    assign coord[1] = i_seg_a_y1;
    assign coord[2] = i_seg_a_x2;
    assign coord[3] = i_seg_a_y2;
    assign coord[4] = i_seg_b_x1;
    assign coord[5] = i_seg_b_y1;
    assign coord[6] = i_seg_b_x2;
    assign coord[7] = i_seg_b_y2;

    sipu_front #(.COORD_BITS(C), .FRAC_BITS(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !r_busy),
        .i_coord (coord),
        .o_valid (f_valid),
        .o_par   (f_par),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_ps    (f_ps),
        .o_qs    (f_qs),
        .o_rs    (f_rs),
        .o_bnd   (f_bnd)
    );

    sipu_div #(.NW(NY), .DW(DY), .SW(SYW)) u_ydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  ({f_par, f_ps, f_qs, f_rs, f_bnd}),
        .o_valid (y_valid),
        .o_quot  (y_quot),
        .o_side  (y_side)
    );

    sipu_xcalc #(.COORD_BITS(C), .FRAC_BITS(F)) u_xcalc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (y_valid),
        .i_par   (y_side[SYW-1]),
        .i_y     (y_quot),
        .i_ps    ($signed(y_side[SYW-2 -: C+1])),
        .i_qs    ($signed(y_side[SYW-C-3 -: C+1])),
        .i_rs    ($signed(y_side[8*C +: 2*C+2])),
        .i_bnd   (y_side[8*C-1:0]),
        .o_valid (c_valid),
        .o_par   (c_par),
        .o_oky   (c_oky),
        .o_yt    (c_yt),
        .o_xnum  (c_xnum),
        .o_pden  (c_pden),
        .o_xbnd  (c_xbnd)
    );

    sipu_div #(.NW(NX), .DW(C+1), .SW(SXW)) u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid),
        .i_num   (c_xnum),
        .i_den   (c_pden),
        .i_side  ({c_par, c_oky, c_yt, c_xbnd}),
        .o_valid (x_valid),
        .o_quot  (x_quot),
        .o_side  (x_side)
    );

    assign x_par  = x_side[SXW-1];
    assign x_oky  = x_side[SXW-2];
    assign x_yt   = $signed(x_side[4*C +: YT]);
    assign x_xbnd = x_side[4*C-1:0];

    // x bounds travel as segment A low/high, then segment B low/high.
    for (genvar s = 0; s < 2; s++) begin : g_xchk
        logic signed [C-1:0] lo, hi;
        logic signed [NX:0]  lo_s, hi_s;
        assign lo   = x_xbnd[(2*s)*C +: C];
        assign hi   = x_xbnd[(2*s+1)*C +: C];
        assign lo_s = (NX+1)'(lo) <<< F;
        assign hi_s = (NX+1)'(hi) <<< F;
        assign n_okx[s] = (x_quot >= lo_s) && (x_quot <= hi_s);
    end

    // A hit keeps both coordinates inside C+F+1 bits, so the narrow forms are exact.
    assign x_ext = SWD'($signed(x_quot[YT-1:0]));
    assign y_ext = SWD'(x_yt);

    always_comb begin
        if (x_par) begin
            n_status = ST_PARALLEL;
        end else if (x_oky && (&n_okx)) begin
            n_status = ST_HIT;
        end else begin
            n_status = ST_OUTSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (n_status != ST_HIT) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            r_x <= (x_ext > SAT_MAX) ? 32'sh7FFF_FFFF :
                   (x_ext < SAT_MIN) ? 32'sh8000_0000 : x_ext[31:0];
            r_y <= (y_ext > SAT_MAX) ? 32'sh7FFF_FFFF :
                   (y_ext < SAT_MIN) ? 32'sh8000_0000 : y_ext[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= x_valid;
        end
    end

    assign o_valid      = r_valid;
    assign o_hit_status = r_status;
    assign o_isect_x    = r_x;
    assign o_isect_y    = r_y;

    a_zero_unless_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_hit_status != ST_HIT) |-> (o_isect_x == '0) && (o_isect_y == '0))
        else $error("coordinates not zero on a miss");

    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_status == ST_HIT) || (o_hit_status == ST_PARALLEL) ||
                    (o_hit_status == ST_OUTSIDE))
        else $error("status code out of range");

    a_reset_flush : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_busy)
        else $error("result or ready seen right after reset");

    a_hit_y_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_valid && (n_status == ST_HIT) |-> x_oky && !x_par)
        else $error("hit without y inside both segments");

endmodule

FILE: tb/sv/segment_intersection_point_unit_test.sv
module segment_intersection_point_unit_test;
    import sipu_pkg::*;

    localparam int CB = DEF_COORD_BITS;
    localparam int FB = DEF_FRAC_BITS;
    localparam int LATENCY = 5 * CB + 2 * FB + 19;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [CB-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    } t_seg_pair;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_crossing;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic signed [CB-1:0] i_seg_a_x1, i_seg_a_y1, i_seg_a_x2, i_seg_a_y2;
    logic signed [CB-1:0] i_seg_b_x1, i_seg_b_y1, i_seg_b_x2, i_seg_b_y2;
    logic                 o_valid;
    logic [1:0]           o_hit_status;
    logic signed [31:0]   o_isect_x, o_isect_y;

    segment_intersection_point_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_seg_a_x1(i_seg_a_x1), .i_seg_a_y1(i_seg_a_y1),
        .i_seg_a_x2(i_seg_a_x2), .i_seg_a_y2(i_seg_a_y2),
        .i_seg_b_x1(i_seg_b_x1), .i_seg_b_y1(i_seg_b_y1),
        .i_seg_b_x2(i_seg_b_x2), .i_seg_b_y2(i_seg_b_y2),
        .o_valid(o_valid), .o_hit_status(o_hit_status),
        .o_isect_x(o_isect_x), .o_isect_y(o_isect_y)
    );

    t_seg_pair pending_pairs[$];
    t_crossing expected_crossings[$];
    int        errors = 0;
    int        cycles = 0;
    int        idle_left = 0;
    bit        calm_phase = 0;
    bit        hold_for_drain = 0;
    bit        stimulus_done = 0;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Exact floor division on 128-bit signed values.
    function automatic logic signed [127:0] floor_div(logic signed [127:0] n,
                                                      logic signed [127:0] d);
        logic signed [127:0] q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic void general_form(logic signed [CB-1:0] x1, logic signed [CB-1:0] y1,
                                         logic signed [CB-1:0] x2, logic signed [CB-1:0] y2,
                                         output logic signed [127:0] p,
                                         output logic signed [127:0] q,
                                         output logic signed [127:0] r);
        logic signed [127:0] dx, dy;
        dx = 128'(x2) - 128'(x1);
        dy = 128'(y1) - 128'(y2);
        if (dx == 0) begin
            p = 1; q = 0; r = 128'(x1);
        end else if (dy == 0) begin
            p = 0; q = 1; r = 128'(y1);
        end else begin
            p = dy; q = dx; r = 128'(y2) * dx + 128'(x2) * dy;
        end
    endfunction

    function automatic bit in_span(logic signed [127:0] v, logic signed [CB-1:0] e1,
                                   logic signed [CB-1:0] e2);
        logic signed [127:0] lo, hi;
        lo = (e1 < e2) ? 128'(e1) : 128'(e2);
        hi = (e1 < e2) ? 128'(e2) : 128'(e1);
        return v >= (lo <<< FB) && v <= (hi <<< FB);
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_crossing predict_crossing(t_seg_pair s);
        logic signed [127:0] pa, qa, ra, pb, qb, rb, det, num, y, x;
        t_crossing c;
        general_form(s.ax1, s.ay1, s.ax2, s.ay2, pa, qa, ra);
        general_form(s.bx1, s.by1, s.bx2, s.by2, pb, qb, rb);
        c.status = ST_PARALLEL;
        c.x = '0;
        c.y = '0;
        det = pa * qb - qa * pb;
        if (det == 0) return c;
        num = pb * ra - rb * pa;
        y = floor_div(num <<< FB, -det);
        if (pa != 0)
            x = floor_div((ra <<< FB) - qa * y, pa);
        else
            x = floor_div((rb <<< FB) - qb * y, pb);
        if (in_span(x, s.ax1, s.ax2) && in_span(y, s.ay1, s.ay2) &&
            in_span(x, s.bx1, s.bx2) && in_span(y, s.by1, s.by2)) begin
            c.status = ST_HIT;
            c.x = clamp32(x);
            c.y = clamp32(y);
        end else begin
            c.status = ST_OUTSIDE;
        end
        return c;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 40)) - 20);
            default: return CB'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Driver: holds start high while items remain, no idle burst is active and no drain is awaited.
    always @(posedge i_clk) begin
        t_seg_pair s;
        if (i_rst_n && i_start && !o_busy) begin
            expected_crossings.push_back(predict_crossing(pending_pairs.pop_front()));
            if (!calm_phase && $urandom_range(0, 15) == 0)
                idle_left = $urandom_range(1, 11);
        end else if (idle_left > 0 && !i_start) begin
            idle_left = idle_left - 1;
        end
        if (i_rst_n && pending_pairs.size() > 0 && idle_left == 0 &&
            !(hold_for_drain && expected_crossings.size() > 0)) begin
            s = pending_pairs[0];
            i_start    <= 1'b1;
            i_seg_a_x1 <= s.ax1; i_seg_a_y1 <= s.ay1;
            i_seg_a_x2 <= s.ax2; i_seg_a_y2 <= s.ay2;
            i_seg_b_x1 <= s.bx1; i_seg_b_y1 <= s.by1;
            i_seg_b_x2 <= s.bx2; i_seg_b_y2 <= s.by2;
        end else begin
            i_start <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_crossing e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (expected_crossings.size() == 0) begin
                $error("result with no item outstanding");
                errors = errors + 1;
            end else begin
                e = expected_crossings.pop_front();
                if (o_hit_status !== e.status) begin
                    $error("hit_status expected %0d actual %0d", e.status, o_hit_status);
                    errors = errors + 1;
                end
                if (o_isect_x !== e.x) begin
                    $error("isect_x expected %0d actual %0d", e.x, o_isect_x);
                    errors = errors + 1;
                end
                if (o_isect_y !== e.y) begin
                    $error("isect_y expected %0d actual %0d", e.y, o_isect_y);
                    errors = errors + 1;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_pair(int ax1, int ay1, int ax2, int ay2,
                            int bx1, int by1, int bx2, int by2);
        t_seg_pair s;
        s.ax1 = CB'(ax1); s.ay1 = CB'(ay1); s.ax2 = CB'(ax2); s.ay2 = CB'(ay2);
        s.bx1 = CB'(bx1); s.by1 = CB'(by1); s.bx2 = CB'(bx2); s.by2 = CB'(by2);
        pending_pairs.push_back(s);
    endtask

    initial begin
        t_seg_pair s;
        int mode;
        int px, py;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        {i_seg_a_x1, i_seg_a_y1, i_seg_a_x2, i_seg_a_y2} = '0;
        {i_seg_b_x1, i_seg_b_y1, i_seg_b_x2, i_seg_b_y2} = '0;

        // Crossing, parallel, collinear, outside, vertical, horizontal, zero length.
        add_pair(0, 0, 10, 10, 0, 10, 10, 0);
        add_pair(0, 0, 10, 10, 0, 1, 10, 11);
        add_pair(0, 0, 10, 10, 5, 5, 20, 20);
        add_pair(0, 0, 1, 1, 10, 0, 20, -10);
        add_pair(3, -5, 3, 5, -5, 2, 5, 2);
        add_pair(-4, 7, 9, 7, 1, -9, 1, 9);
        add_pair(2, 2, 2, 2, 0, 0, 4, 4);
        add_pair(2, 2, 2, 2, 3, 3, 3, 3);
        add_pair(0, 0, 3, 1, 0, 1, 1, 0);
        add_pair(0, 0, 0, 5, 0, 7, 0, 9);
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        add_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32766);
        add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        add_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
        add_pair(-1, -1, 1, 1, -1, 1, 1, -1);
        add_pair(-32768, 1, 32767, -1, -1, -32768, 1, 32767);
        add_pair(0, 0, 7, 3, 1, 5, 6, -2);
        add_pair(10, 0, 0, 10, 0, 0, 10, 10);

        for (int n = 0; n < 1030; n++) begin
            mode = $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) begin
                s = {$urandom, $urandom, $urandom, $urandom};
            end else if ($urandom_range(0, 4) == 0) begin
                // Parallel pair: segment B is A shifted.
                s.ax1 = rand_coord(mode); s.ay1 = rand_coord(mode);
                s.ax2 = rand_coord(mode); s.ay2 = rand_coord(mode);
                px = $urandom_range(0, 20) - 10; py = $urandom_range(0, 20) - 10;
                s.bx1 = s.ax1 + CB'(px); s.by1 = s.ay1 + CB'(py);
                s.bx2 = s.ax2 + CB'(px); s.by2 = s.ay2 + CB'(py);
            end else begin
                // Both segments are built around a common point.
                px = rand_coord(mode); py = rand_coord(mode);
                s.ax1 = CB'(px) - rand_coord(1); s.ay1 = CB'(py) - rand_coord(1);
                s.ax2 = CB'(px) + rand_coord(1); s.ay2 = CB'(py) + rand_coord(1);
                s.bx1 = CB'(px) - rand_coord(1); s.by1 = CB'(py) + rand_coord(1);
                s.bx2 = CB'(px) + rand_coord(1); s.by2 = CB'(py) - rand_coord(1);
            end
            pending_pairs.push_back(s);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_pairs.size() < 600);
        hold_for_drain = 1;
        wait (expected_crossings.size() == 0);
        hold_for_drain = 0;
        wait (pending_pairs.size() < 150);
        calm_phase = 1;
        wait (pending_pairs.size() == 0 && expected_crossings.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_crossings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: sim.f
sv/sipu_pkg.sv
sv/sipu_front.sv
sv/sipu_div.sv
sv/sipu_xcalc.sv
sv/segment_intersection_point_unit.sv
tb/sv/segment_intersection_point_unit_test.sv
